// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms used by the rtl modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/qts_pkg.sv =====
// ----------------------------------------------------------------------------
// qts_pkg
// types, codes and constants of the quote aware token splitter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qts_pkg;

  localparam int QTS_FIFO_DEPTH = 4;

  // characters of interest
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // result kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_OK   = 2'd2;
  localparam logic [1:0] KIND_ERR  = 2'd3;

  // error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_QUOTE     = 2'd1;
  localparam logic [1:0] ERR_BACKSLASH = 2'd2;

  // scanner modes
  typedef enum logic [5:0] {
    M_BETWEEN  = 6'b000001,
    M_BARE     = 6'b000010,
    M_BARE_ESC = 6'b000100,
    M_SQ       = 6'b001000,
    M_DQ       = 6'b010000,
    M_DQ_ESC   = 6'b100000
  } scan_mode_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] token_byte;
    logic [1:0] error_code;
    logic [7:0] token_count;
    logic       last;
  } result_t;

  // results caused by one input byte
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } step_t;

  function automatic result_t mk_result(logic [1:0] kind, logic [7:0] b,
                                        logic [1:0] err, logic [7:0] cnt,
                                        logic last);
    result_t r;
    r.kind        = kind;
    r.token_byte  = b;
    r.error_code  = err;
    r.token_count = cnt;
    r.last        = last;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/quote_aware_token_splitter.sv =====
// ----------------------------------------------------------------------------
// quote_aware_token_splitter
// splits a zero-terminated command line into shell-style quoted tokens
// ----------------------------------------------------------------------------
// channel  direction  payload
// s_axis   in         tdata[7:0] line_byte
// m_axis   out        tdata[7:0] token_byte, [9:8] error_code,
//                     [17:10] token_count; tuser result_kind; tlast last_of_item
//
// one byte is taken per cycle while s_axis_tready is high; its results are queued at the same edge
// a byte yields zero, one or two results; the queue drains one per cycle while m_axis_tready is high
// s_axis_tready drops only while the queue has fewer than two free slots
// rst is synchronous and returns the scanner to between tokens, count zero
// results are registered in the queue, never passed to m_axis in the same cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module quote_aware_token_splitter
  import qts_pkg::*;
#(
  parameter int FIFO_DEPTH = QTS_FIFO_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input byte stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] line_byte
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [7:0] token_byte, [9:8] error_code,
                                           // [17:10] token_count, rest zero
  output logic [1:0]       m_axis_tuser,   // [1:0] result_kind
  output logic             m_axis_tlast    // last result of an input byte
);

  logic    in_fire;
  step_t   step;
  result_t head;

  // input transfer completes when the queue can absorb a result pair
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // mode and token count, plus decode of the current byte
  qts_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .fire      (in_fire),
    .line_byte (s_axis_tdata),
    .step      (step)
  );

  // result queue decouples the stall on m_axis from input transfers
  qts_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (in_fire),
    .step      (step),
    .room      (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (head)
  );

  // pack the head result onto the master side
  assign m_axis_tdata = {6'd0, head.token_count, head.error_code, head.token_byte};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule

`default_nettype wire

// ===== rtl/qts_scan.sv =====
// ----------------------------------------------------------------------------
// qts_scan
// scanner state and per-byte decode into up to two results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module qts_scan
  import qts_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       fire,
  input  wire logic [7:0] line_byte,
  output step_t           step
);

  scan_mode_t mode, mode_next;
  logic [7:0] tokens_seen, tokens_seen_next;
  logic [7:0] tokens_inc;
  logic       is_sep;

  assign tokens_inc = (tokens_seen == 8'hFF) ? tokens_seen : tokens_seen + 8'd1;
  assign is_sep     = line_byte inside {CH_SPACE, CH_TAB, CH_LF, CH_CR};

  always_comb begin
    mode_next        = mode;
    tokens_seen_next = tokens_seen;
    step.n           = 2'd0;
    step.r0          = '0;
    step.r1          = '0;
    if (line_byte == CH_NUL) begin
      mode_next        = M_BETWEEN;
      tokens_seen_next = 8'd0;
      step.n           = 2'd1;
      case (mode)
        M_BARE: begin
          step.n  = 2'd2;
          step.r0 = mk_result(KIND_END, 8'd0, ERR_NONE, 8'd0, 1'b0);
          step.r1 = mk_result(KIND_OK, 8'd0, ERR_NONE, tokens_inc, 1'b1);
        end
        M_BARE_ESC: begin
          step.r0 = mk_result(KIND_ERR, 8'd0, ERR_BACKSLASH, tokens_seen, 1'b1);
        end
        M_SQ, M_DQ, M_DQ_ESC: begin
          step.r0 = mk_result(KIND_ERR, 8'd0, ERR_QUOTE, tokens_seen, 1'b1);
        end
        default: begin
          step.r0 = mk_result(KIND_OK, 8'd0, ERR_NONE, tokens_seen, 1'b1);
        end
      endcase
    end else begin
      case (mode)
        M_BARE: begin
          if (is_sep) begin
            tokens_seen_next = tokens_inc;
            step.n           = 2'd1;
            step.r0          = mk_result(KIND_END, 8'd0, ERR_NONE, 8'd0, 1'b1);
            mode_next        = M_BETWEEN;
          end else if (line_byte == CH_SQUOTE) begin
            mode_next = M_SQ;
          end else if (line_byte == CH_DQUOTE) begin
            mode_next = M_DQ;
          end else if (line_byte == CH_BSLASH) begin
            mode_next = M_BARE_ESC;
          end else begin
            step.n  = 2'd1;
            step.r0 = mk_result(KIND_BYTE, line_byte, ERR_NONE, 8'd0, 1'b1);
          end
        end
        M_BARE_ESC: begin
          step.n    = 2'd1;
          step.r0   = mk_result(KIND_BYTE, line_byte, ERR_NONE, 8'd0, 1'b1);
          mode_next = M_BARE;
        end
        M_SQ: begin
          if (line_byte == CH_SQUOTE) begin
            mode_next = M_BARE;
          end else begin
            step.n  = 2'd1;
            step.r0 = mk_result(KIND_BYTE, line_byte, ERR_NONE, 8'd0, 1'b1);
          end
        end
        M_DQ: begin
          if (line_byte == CH_DQUOTE) begin
            mode_next = M_BARE;
          end else if (line_byte == CH_BSLASH) begin
            mode_next = M_DQ_ESC;
          end else begin
            step.n  = 2'd1;
            step.r0 = mk_result(KIND_BYTE, line_byte, ERR_NONE, 8'd0, 1'b1);
          end
        end
        M_DQ_ESC: begin
          step.n    = 2'd1;
          step.r0   = mk_result(KIND_BYTE, line_byte, ERR_NONE, 8'd0, 1'b1);
          mode_next = M_DQ;
        end
        default: begin
          if (is_sep) begin
            mode_next = M_BETWEEN;
          end else if (line_byte == CH_SQUOTE) begin
            mode_next = M_SQ;
          end else if (line_byte == CH_DQUOTE) begin
            mode_next = M_DQ;
          end else if (line_byte == CH_BSLASH) begin
            mode_next = M_BARE_ESC;
          end else begin
            step.n    = 2'd1;
            step.r0   = mk_result(KIND_BYTE, line_byte, ERR_NONE, 8'd0, 1'b1);
            mode_next = M_BARE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= M_BETWEEN;
      tokens_seen <= 8'd0;
    end else if (fire) begin
      mode        <= mode_next;
      tokens_seen <= tokens_seen_next;
    end
  end

  // line end always returns the scanner to its idle state
  `ASSERT_NEXT(a_line_end_clears, clk, rst, fire && (line_byte == CH_NUL), (tokens_seen == 8'd0) && (mode == M_BETWEEN), "scanner not cleared after line end")
  // a pair of results only comes from a bare token cut by line end
  `ASSERT_ALWAYS(a_pair_is_end_ok, clk, rst, (step.n != 2'd2) || ((step.r0.kind == KIND_END) && (step.r1.kind == KIND_OK)), "unexpected result pair")

endmodule

`default_nettype wire

// ===== rtl/qts_fifo.sv =====
// ----------------------------------------------------------------------------
// qts_fifo
// result queue taking up to two results per cycle and giving one while out_ready is high
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module qts_fifo
  import qts_pkg::*;
#(
  parameter int DEPTH = QTS_FIFO_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire step_t step,
  output logic       room,
  output logic       out_valid,
  input  wire logic  out_ready,
  output result_t    out_data
);

  localparam int PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST  = PW'(DEPTH - 1);
  localparam logic [CW-1:0] ROOM_MAX  = CW'(DEPTH - 2);

  result_t       mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr, wr_ptr_1, wr_ptr_2, rd_ptr_1;
  logic [CW-1:0] count;
  logic [1:0]    n_push;
  logic          pop;

  assign wr_ptr_1  = (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PW'(1);
  assign wr_ptr_2  = (wr_ptr_1 == PTR_LAST) ? '0 : wr_ptr_1 + PW'(1);
  assign rd_ptr_1  = (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PW'(1);
  assign n_push    = push ? step.n : 2'd0;
  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign room      = (count <= ROOM_MAX);
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem[wr_ptr] <= step.r0;
    end
    if (n_push == 2'd2) begin
      mem[wr_ptr_1] <= step.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count + CW'(n_push) - CW'(pop);
      if (n_push == 2'd1) begin
        wr_ptr <= wr_ptr_1;
      end else if (n_push == 2'd2) begin
        wr_ptr <= wr_ptr_2;
      end
      if (pop) begin
        rd_ptr <= rd_ptr_1;
      end
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CW'(DEPTH), "result queue over depth")
  `ASSERT_ALWAYS(a_push_fits, clk, rst, (n_push == 2'd0) || room, "push without room")
  `ASSERT_NEXT(a_pop_only, clk, rst, pop && (n_push == 2'd0), count == $past(count) - CW'(1), "count did not drop on pop")

endmodule

`default_nettype wire
